// ----- rtl/srsr_pkg.sv -----
// types and constants shared by the selective-repeat sack receiver
package srsr_pkg;

  localparam int unsigned SEQ_W = 31;
  localparam int unsigned BLK_W = 24;
  localparam int unsigned CNT_W = 9;

  typedef enum logic [1:0] {
    VERDICT_IN_ORDER  = 2'd0,
    VERDICT_SACKED    = 2'd1,
    VERDICT_CORRUPTED = 2'd2,
    VERDICT_OVERFLOW  = 2'd3
  } verdict_e;

  typedef struct packed {
    logic [SEQ_W-1:0] seq_number;
    logic             fin_bit;
    logic             crc_ok;
  } in_item_t;

  typedef struct packed {
    logic [SEQ_W-1:0] ack_number;
    logic [SEQ_W-1:0] sack_number;
    logic             fin_ack;
    verdict_e         verdict;
    logic             flush_now;
    logic [CNT_W-1:0] flush_count;
    logic             done_res;
  } out_item_t;

endpackage

// ----- rtl/srsr_first_zero.sv -----
// first-zero priority encoder over the received bitmap
module srsr_first_zero #(
  parameter int unsigned WINDOW = 256,
  parameter int unsigned IDX_W  = $clog2(WINDOW + 1)
) (
  input  logic [WINDOW-1:0] map_i,
  output logic [IDX_W-1:0]  idx_o,
  output logic              full_o
);

  logic [WINDOW-1:0] zeros;
  logic [WINDOW-1:0] lowest;
  logic [IDX_W-1:0]  idx_enc;

  // isolate the lowest clear bit with one wide add
  assign zeros  = ~map_i;
  assign lowest = zeros & (~zeros + {{(WINDOW-1){1'b0}}, 1'b1});
  assign full_o = ~(|zeros);

  always_comb begin
    idx_enc = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (lowest[i]) begin
        idx_enc = idx_enc | IDX_W'(i);
      end
    end
  end

  assign idx_o = full_o ? IDX_W'(WINDOW) : idx_enc;

endmodule

// ----- rtl/selective_repeat_sack_receiver.sv -----
// selective-repeat receiver with sack: one header in, at most one ack out
// result path: input reg, then result reg
// throughput: one item per cycle unless the output stalls; the bitmap mark and first-zero
//   encode over the window sit in one pass between the input and result registers
// reset: base 1, block 0, bitmap clear, fin and finished flags clear
// after a completed fin every item is consumed with no result
module selective_repeat_sack_receiver
  import srsr_pkg::*;
#(
  parameter int unsigned WINDOW = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned IDX_W  = $clog2(WINDOW + 1);
  localparam int unsigned SLOT_W = $clog2(WINDOW);
  localparam int unsigned EXT_W  =
    (BLK_W + IDX_W + 1 > SEQ_W + 1) ? (BLK_W + IDX_W + 1) : (SEQ_W + 1);
  localparam int unsigned CNT_X  = (IDX_W > CNT_W) ? IDX_W : CNT_W;

  logic              in_valid_q;
  in_item_t          in_item_q;
  logic              out_valid_q;
  out_item_t         out_item_q;

  logic [SEQ_W-1:0]  next_q, next_d;
  logic [BLK_W-1:0]  block_q, block_d;
  logic [WINDOW-1:0] map_q, map_d;
  logic              fin_seen_q, fin_seen_d;
  logic              finished_q, finished_d;

  logic              advance;
  logic              take_in;
  logic              update;

  logic [EXT_W-1:0]  first;
  logic [EXT_W-1:0]  blk_end;
  logic [EXT_W-1:0]  seq_ext;
  logic [EXT_W-1:0]  offset;
  logic              in_blk;
  logic [SLOT_W-1:0] slot;
  logic [WINDOW-1:0] mark;
  logic [WINDOW-1:0] map_m;
  logic [IDX_W-1:0]  zero_idx;
  logic              map_full;
  logic [CNT_X-1:0]  idx_x;
  logic [EXT_W-1:0]  new_base;
  logic [SEQ_W-1:0]  ack_cur;
  logic              fin_now;
  out_item_t         res;

  // input register frees up whenever the result register can move
  assign advance    = ~out_valid_q | out_ready_i;
  assign in_ready_o = ~in_valid_q | advance;
  assign take_in    = in_valid_i & in_ready_o;
  assign update     = in_valid_q & advance & ~finished_q;

  // block bounds without wrap
  assign first   = EXT_W'(block_q) * EXT_W'(WINDOW) + EXT_W'(1);
  assign blk_end = (EXT_W'(block_q) + EXT_W'(1)) * EXT_W'(WINDOW);
  assign seq_ext = EXT_W'(in_item_q.seq_number);
  assign offset  = seq_ext - first;
  assign in_blk  = (seq_ext >= first) && (offset < EXT_W'(WINDOW));
  assign slot    = offset[SLOT_W-1:0];
  assign mark    = in_blk ? ({{(WINDOW-1){1'b0}}, 1'b1} << slot) : '0;
  assign map_m   = map_q | mark;

  srsr_first_zero #(
    .WINDOW (WINDOW),
    .IDX_W  (IDX_W)
  ) u_first_zero (
    .map_i  (map_m),
    .idx_o  (zero_idx),
    .full_o (map_full)
  );

  assign idx_x    = CNT_X'(zero_idx);
  assign new_base = first + EXT_W'(zero_idx);
  assign ack_cur  = next_q - SEQ_W'(1);
  assign fin_now  = fin_seen_q | in_item_q.fin_bit;

  always_comb begin
    next_d          = next_q;
    block_d         = block_q;
    map_d           = map_q;
    fin_seen_d      = fin_seen_q;
    finished_d      = finished_q;
    res.ack_number  = ack_cur;
    res.sack_number = ack_cur;
    res.fin_ack     = 1'b0;
    res.verdict     = VERDICT_CORRUPTED;
    res.flush_now   = 1'b0;
    res.flush_count = '0;
    res.done_res    = 1'b0;
    if (in_item_q.crc_ok) begin
      fin_seen_d = fin_now;
      if (in_item_q.seq_number == next_q) begin
        next_d          = new_base[SEQ_W-1:0];
        res.ack_number  = new_base[SEQ_W-1:0] - SEQ_W'(1);
        res.sack_number = in_item_q.seq_number;
        res.fin_ack     = fin_now;
        res.verdict     = VERDICT_IN_ORDER;
        map_d           = map_m;
        if (fin_now) begin
          res.flush_now   = 1'b1;
          res.flush_count = idx_x[CNT_W-1:0];
          res.done_res    = 1'b1;
          finished_d      = 1'b1;
        end else if (map_full) begin
          res.flush_now   = 1'b1;
          res.flush_count = idx_x[CNT_W-1:0];
          block_d         = block_q + BLK_W'(1);
          map_d           = '0;
        end
      end else if (seq_ext > blk_end) begin
        res.verdict = VERDICT_OVERFLOW;
      end else begin
        map_d           = map_m;
        res.sack_number = in_item_q.seq_number;
        res.fin_ack     = fin_now;
        res.verdict     = VERDICT_SACKED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      next_q      <= SEQ_W'(1);
      block_q     <= '0;
      map_q       <= '0;
      fin_seen_q  <= 1'b0;
      finished_q  <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= update;
      end
      if (update) begin
        next_q     <= next_d;
        block_q    <= block_d;
        map_q      <= map_d;
        fin_seen_q <= fin_seen_d;
        finished_q <= finished_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_item_q <= in_item_i;
    end
    if (update) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ----- rtl/srsr_checker.sv -----
// port-level checks for the selective-repeat sack receiver, bound to the top level
module srsr_checker
  import srsr_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // count only travels with a flush
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.flush_now |-> out_item_o.flush_count == '0)
    else $error("flush count without flush");

  // transfer end is an in-order flush with fin echoed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.done_res |->
      out_item_o.flush_now && out_item_o.fin_ack &&
      out_item_o.verdict == VERDICT_IN_ORDER)
    else $error("done without in-order fin flush");

  // dropped items re-ack base with no fin and no flush
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.verdict == VERDICT_CORRUPTED ||
                    out_item_o.verdict == VERDICT_OVERFLOW) |->
      out_item_o.sack_number == out_item_o.ack_number &&
      !out_item_o.fin_ack && !out_item_o.flush_now)
    else $error("bad answer for dropped item");

  // nothing follows the final ack
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_item_o.done_res |=> !out_valid_o)
    else $error("result after transfer end");

endmodule

bind selective_repeat_sack_receiver srsr_checker u_srsr_checker (.*);

// ----- test/tb.sv -----
// testbench for the selective-repeat sack receiver: directed and random segment streams checked against a predictor
`timescale 1ns / 100ps

module tb;
  import srsr_pkg::*;

  localparam int unsigned WINDOW = 256;
  localparam int unsigned RANDOM_SEGMENTS = 430;
  localparam int unsigned HOLD_CYCLES = 64;
  localparam int unsigned QUIET_LIMIT = 5000;

  // receiver state as seen from outside
  typedef struct {
    bit [SEQ_W-1:0]  base;
    bit [BLK_W-1:0]  blk;
    bit [WINDOW-1:0] got;
    bit              fin_seen;
    bit              done;
  } rx_view_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item = '0;
  logic      out_valid_o;
  logic      out_ready = 1'b0;
  out_item_t out_item_o;

  rx_view_t  rx_model;
  rx_view_t  sender_view;
  in_item_t  segments_to_send[$];
  out_item_t pending_acks[$];
  int        total_items;
  int        loaded_cnt;
  int        acks_seen;
  int        hold_cycles;
  int        mismatch_cnt;
  int        quiet_cycles;

  selective_repeat_sack_receiver #(
    .WINDOW(WINDOW)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_item_o (out_item_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic void reset_view(output rx_view_t s);
    s.base = 1;
    s.blk = '0;
    s.got = '0;
    s.fin_seen = 1'b0;
    s.done = 1'b0;
  endfunction

  // returns 1 when the segment produces an ack
  function automatic bit answer_segment(inout rx_view_t s, input in_item_t seg,
                                        output out_item_t ack);
    longint unsigned seq, first, lim, nb;
    int unsigned slot;
    int i;
    ack = '0;
    if (s.done) return 1'b0;
    seq = 64'(seg.seq_number);
    first = {40'd0, s.blk} * WINDOW + 1;
    lim = ({40'd0, s.blk} + 1) * WINDOW;
    ack.ack_number = s.base - 1'b1;
    ack.sack_number = ack.ack_number;
    if (!seg.crc_ok) begin
      ack.verdict = VERDICT_CORRUPTED;
      return 1'b1;
    end
    if (seg.fin_bit) s.fin_seen = 1'b1;
    if (seq == {33'd0, s.base}) begin
      if (seq >= first && seq - first < WINDOW) s.got[seq - first] = 1'b1;
      // first hole in the block, or one past its end
      slot = WINDOW;
      for (i = WINDOW - 1; i >= 0; i--) begin
        if (!s.got[i]) slot = i;
      end
      nb = first + slot;
      s.base = nb[SEQ_W-1:0];
      ack.ack_number = s.base - 1'b1;
      ack.sack_number = seq[SEQ_W-1:0];
      ack.fin_ack = s.fin_seen;
      ack.verdict = VERDICT_IN_ORDER;
      if (s.fin_seen) begin
        ack.flush_now = 1'b1;
        ack.flush_count = slot[CNT_W-1:0];
        ack.done_res = 1'b1;
        s.done = 1'b1;
      end else if (slot == WINDOW) begin
        ack.flush_now = 1'b1;
        ack.flush_count = slot[CNT_W-1:0];
        s.blk = s.blk + 1'b1;
        s.got = '0;
      end
    end else if (seq > lim) begin
      ack.verdict = VERDICT_OVERFLOW;
    end else begin
      // below the block start nothing gets marked
      if (seq >= first && seq - first < WINDOW) s.got[seq - first] = 1'b1;
      ack.sack_number = seq[SEQ_W-1:0];
      ack.fin_ack = s.fin_seen;
      ack.verdict = VERDICT_SACKED;
    end
    return 1'b1;
  endfunction

  task automatic queue_segment(input longint unsigned seq, input bit fin, input bit ok);
    in_item_t  seg;
    out_item_t unused;
    seg.seq_number = seq[SEQ_W-1:0];
    seg.fin_bit = fin;
    seg.crc_ok = ok;
    segments_to_send.push_back(seg);
    void'(answer_segment(sender_view, seg, unused));
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatch_cnt++;
    end
  endtask

  // driver: predicts on every accepted item, then offers the next one
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    int idle_pct;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_item <= '0;
    end else begin
      if (in_valid && in_ready_o) begin
        if (answer_segment(rx_model, in_item, want)) pending_acks.push_back(want);
      end
      if (!in_valid || in_ready_o) begin
        idle_pct = (loaded_cnt < total_items / 3) ? 30 :
                   (loaded_cnt < 2 * total_items / 3) ? 75 : 0;
        // halfway through, stop offering until every ack is back
        if (segments_to_send.size() != 0 &&
            !(loaded_cnt == total_items / 2 && pending_acks.size() != 0) &&
            $urandom_range(99) >= idle_pct) begin
          in_valid <= 1'b1;
          in_item <= segments_to_send.pop_front();
          loaded_cnt++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compares each ack with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    int idle_pct;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        acks_seen++;
        if (pending_acks.size() == 0) begin
          $display("%0t: ack with none pending, expected none, actual %h", $time, out_item_o);
          mismatch_cnt++;
        end else begin
          want = pending_acks.pop_front();
          check_field("ack_number", 32'(want.ack_number), 32'(out_item_o.ack_number));
          check_field("sack_number", 32'(want.sack_number), 32'(out_item_o.sack_number));
          check_field("fin_ack", 32'(want.fin_ack), 32'(out_item_o.fin_ack));
          check_field("verdict", 32'(want.verdict), 32'(out_item_o.verdict));
          check_field("flush_now", 32'(want.flush_now), 32'(out_item_o.flush_now));
          check_field("flush_count", 32'(want.flush_count), 32'(out_item_o.flush_count));
          check_field("done_res", 32'(want.done_res), 32'(out_item_o.done_res));
        end
      end
      idle_pct = (acks_seen < total_items / 3) ? 75 :
                 (acks_seen < 2 * total_items / 3) ? 30 : 0;
      // one long back-pressure stretch so the block fills and stalls its input
      if (acks_seen >= 2 * total_items / 3 + 20 && hold_cycles < HOLD_CYCLES) begin
        out_ready <= 1'b0;
        hold_cycles++;
      end else begin
        out_ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    longint unsigned b, lim, first, seq;
    int r;
    reset_view(rx_model);
    reset_view(sender_view);

    // directed: field extremes and the special cases
    queue_segment(0, 1'b0, 1'b1);              // below the block, sacked
    queue_segment(64'h7FFF_FFFF, 1'b0, 1'b1);  // far beyond the window
    queue_segment(64'h7FFF_FFFF, 1'b1, 1'b0);  // corrupt, fin not recorded
    queue_segment(1, 1'b0, 1'b1);              // first in order
    queue_segment(1, 1'b0, 1'b1);              // duplicate
    queue_segment(64'(WINDOW), 1'b0, 1'b1);    // last slot of the block
    queue_segment(64'(WINDOW + 1), 1'b0, 1'b1); // just beyond the window
    queue_segment(3, 1'b0, 1'b1);
    queue_segment(5, 1'b0, 1'b1);
    queue_segment(2, 1'b0, 1'b1);              // in order, base jumps over 3
    queue_segment(0, 1'b0, 1'b0);
    queue_segment(4, 1'b1, 1'b0);              // corrupt copy of base
    queue_segment(4, 1'b0, 1'b1);

    // random: mostly near-order delivery with noise around it
    for (int n = 0; n < RANDOM_SEGMENTS; n++) begin
      b = 64'(sender_view.base);
      first = {40'd0, sender_view.blk} * WINDOW + 1;
      lim = ({40'd0, sender_view.blk} + 1) * WINDOW;
      r = $urandom_range(99);
      if (r < 45) begin
        queue_segment(b, 1'b0, 1'b1);
      end else if (r < 65) begin
        seq = b + $urandom_range(1, 6);
        queue_segment((seq > lim) ? b : seq, 1'b0, 1'b1);
      end else if (r < 77) begin
        queue_segment(64'($urandom & 32'h7FFF_FFFF), 1'($urandom_range(1)), 1'b0);
      end else if (r < 85) begin
        if ($urandom_range(1)) queue_segment(lim + 1 + $urandom_range(40), 1'b0, 1'b1);
        else queue_segment(64'($urandom & 32'h7FFF_FFFF), 1'b0, 1'b1);
      end else if (r < 92) begin
        queue_segment(64'($urandom_range(0, b - 1)), 1'b0, 1'b1);
      end else begin
        queue_segment(first + $urandom_range(WINDOW - 1), 1'b0, 1'b1);
      end
    end

    // fin beyond the window, then out of order with fin echoed, then completion
    b = 64'(sender_view.base);
    lim = ({40'd0, sender_view.blk} + 1) * WINDOW;
    queue_segment(lim + 5, 1'b1, 1'b1);
    if (b + 1 <= lim) queue_segment(b + 1, 1'b0, 1'b1);
    queue_segment(b, 1'b0, 1'b1);
    // transfer over: these are swallowed
    queue_segment(b + 1, 1'b1, 1'b1);
    queue_segment(64'($urandom & 32'h7FFF_FFFF), 1'b0, 1'b0);
    queue_segment(0, 1'b0, 1'b1);
    total_items = segments_to_send.size();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (segments_to_send.size() != 0 || in_valid || pending_acks.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
